FILE: src/gosq_pkg.sv
// Shared types and constants of the GNSS outage status qualifier.
`default_nettype none
package gosq_pkg;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP_MS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTAGE_ACC_CM   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_ACC_CM = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTAGE_DOP      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_DOP    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTAGE_SIGNAL   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEGRADED_SIGNAL = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE     = 4'd7;

  localparam logic [1:0] CLS_GOOD       = 2'd0;
  localparam logic [1:0] CLS_DEGRADED   = 2'd1;
  localparam logic [1:0] CLS_OUTAGE     = 2'd2;
  localparam logic [1:0] CLS_RECOVERING = 2'd3;

  typedef struct packed {
    logic [19:0] max_gap_ms;
    logic [15:0] outage_acc_cm;
    logic [15:0] degraded_acc_cm;
    logic [15:0] outage_dop;
    logic [15:0] degraded_dop;
    logic [9:0]  outage_signal;
    logic [9:0]  degraded_signal;
    logic [7:0]  persistence;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_gap_ms:      20'd2000,
    outage_acc_cm:   16'd5000,
    degraded_acc_cm: 16'd1500,
    outage_dop:      16'd500,
    degraded_dop:    16'd200,
    outage_signal:   10'd200,
    degraded_signal: 10'd300,
    persistence:     8'd3
  };

endpackage
`default_nettype wire

FILE: src/gosq_cfg_regs.sv
// Configuration register file of the GNSS outage status qualifier.
`default_nettype none
module gosq_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [gosq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gosq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output gosq_pkg::cfg_t                        cfg
);

  gosq_pkg::cfg_t cfg_r;
  gosq_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gosq_pkg::REG_MAX_GAP_MS:      cfg_nxt.max_gap_ms      = cfg_wdata;
        gosq_pkg::REG_OUTAGE_ACC_CM:   cfg_nxt.outage_acc_cm   = cfg_wdata[15:0];
        gosq_pkg::REG_DEGRADED_ACC_CM: cfg_nxt.degraded_acc_cm = cfg_wdata[15:0];
        gosq_pkg::REG_OUTAGE_DOP:      cfg_nxt.outage_dop      = cfg_wdata[15:0];
        gosq_pkg::REG_DEGRADED_DOP:    cfg_nxt.degraded_dop    = cfg_wdata[15:0];
        gosq_pkg::REG_OUTAGE_SIGNAL:   cfg_nxt.outage_signal   = cfg_wdata[9:0];
        gosq_pkg::REG_DEGRADED_SIGNAL: cfg_nxt.degraded_signal = cfg_wdata[9:0];
        gosq_pkg::REG_PERSISTENCE:     cfg_nxt.persistence     = cfg_wdata[7:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= gosq_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: src/gosq_classify.sv
// Instant classifier with the last-fix time tracker.
`default_nettype none
module gosq_classify #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           upd,
  input  wire logic           fix_present,
  input  wire logic [31:0]    obs_time_ms,
  input  wire logic [15:0]    accuracy_cm,
  input  wire logic [15:0]    dop_x100,
  input  wire logic [9:0]     signal_x10,
  input  wire gosq_pkg::cfg_t cfg,
  output logic [1:0]          cls
);

  localparam int unsigned GAP_W = (TIME_WIDTH > 20) ? TIME_WIDTH : 20;

  logic [TIME_WIDTH-1:0] t;
  logic [TIME_WIDTH-1:0] last_fix_time_r;
  logic                  last_fix_valid_r;
  logic [TIME_WIDTH-1:0] gap;
  logic [GAP_W-1:0]      gap_ext;
  logic [GAP_W-1:0]      max_ext;
  logic                  long_gap;

  if (TIME_WIDTH > 32) begin : g_wide
    assign t = {{(TIME_WIDTH-32){1'b0}}, obs_time_ms};
  end else begin : g_narrow
    assign t = obs_time_ms[TIME_WIDTH-1:0];
  end

  assign gap      = t - last_fix_time_r;
  assign gap_ext  = GAP_W'(gap);
  assign max_ext  = GAP_W'(cfg.max_gap_ms);
  assign long_gap = last_fix_valid_r && !gap[TIME_WIDTH-1] && (gap_ext > max_ext);

  always_comb begin
    cls = gosq_pkg::CLS_GOOD;
    if (!fix_present || long_gap) begin
      cls = gosq_pkg::CLS_OUTAGE;
    end else if (accuracy_cm != 16'd0 && accuracy_cm >= cfg.outage_acc_cm) begin
      cls = gosq_pkg::CLS_OUTAGE;
    end else if (accuracy_cm != 16'd0 && accuracy_cm >= cfg.degraded_acc_cm) begin
      cls = gosq_pkg::CLS_DEGRADED;
    end else if (dop_x100 != 16'd0 && dop_x100 >= cfg.outage_dop) begin
      cls = gosq_pkg::CLS_OUTAGE;
    end else if (dop_x100 != 16'd0 && dop_x100 >= cfg.degraded_dop) begin
      cls = gosq_pkg::CLS_DEGRADED;
    end else if (signal_x10 != 10'd0 && signal_x10 <= cfg.outage_signal) begin
      cls = gosq_pkg::CLS_OUTAGE;
    end else if (signal_x10 != 10'd0 && signal_x10 <= cfg.degraded_signal) begin
      cls = gosq_pkg::CLS_DEGRADED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_fix_time_r  <= '0;
      last_fix_valid_r <= 1'b0;
    end else if (upd && fix_present) begin
      last_fix_time_r  <= t;
      last_fix_valid_r <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/gosq_status.sv
// Persistence filter that turns instant classes into the qualified status.
`default_nettype none
module gosq_status #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       upd,
  input  wire logic [1:0] cls,
  input  wire logic [7:0] persistence,
  output logic [1:0]      status_nxt
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [1:0]             status_r;
  logic [1:0]             pending_r;
  logic [1:0]             pending_nxt;
  logic [COUNT_WIDTH-1:0] count_r;
  logic [COUNT_WIDTH-1:0] count_nxt;
  logic [1:0]             pend_tmp;
  logic [COUNT_WIDTH-1:0] count_tmp;

  always_comb begin
    status_nxt  = status_r;
    pending_nxt = pending_r;
    count_nxt   = count_r;
    pend_tmp    = pending_r;
    count_tmp   = count_r;
    if (cls == status_r) begin
      count_nxt   = '0;
      pending_nxt = status_r;
    end else begin
      if (cls == pending_r) begin
        if (count_r != COUNT_MAX) begin
          count_tmp = count_r + COUNT_WIDTH'(1);
        end
      end else begin
        pend_tmp  = cls;
        count_tmp = COUNT_WIDTH'(1);
      end
      pending_nxt = pend_tmp;
      count_nxt   = count_tmp;
      if (CMP_W'(count_tmp) >= CMP_W'(persistence)) begin
        if (status_r == gosq_pkg::CLS_OUTAGE && pend_tmp == gosq_pkg::CLS_GOOD) begin
          status_nxt = gosq_pkg::CLS_RECOVERING;
        end else begin
          status_nxt = pend_tmp;
        end
        count_nxt   = '0;
        pending_nxt = status_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= gosq_pkg::CLS_GOOD;
      pending_r <= gosq_pkg::CLS_GOOD;
      count_r   <= '0;
    end else if (upd) begin
      status_r  <= status_nxt;
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/gnss_outage_status_qualifier_top.sv
// Each accepted item passes through the input register, then the result register.
// Throughput: one transaction per cycle unless out_ready stalls the result register.
// The last-fix time and status state update as an item moves into the result register.
// Reset is synchronous and active low; it clears the pipeline valids, the status
// state and the configuration registers to their default values.
`default_nettype none
module gnss_outage_status_qualifier_top #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [gosq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gosq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_fix_present,
  input  wire logic [31:0]                     in_obs_time_ms,
  input  wire logic [15:0]                     in_accuracy_cm,
  input  wire logic [15:0]                     in_dop_x100,
  input  wire logic [9:0]                      in_signal_x10,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_instant_class,
  output logic [1:0]                           out_nav_status
);

  gosq_pkg::cfg_t cfg;

  logic        s1_valid_r;
  logic        s1_fix_r;
  logic [31:0] s1_time_r;
  logic [15:0] s1_acc_r;
  logic [15:0] s1_dop_r;
  logic [9:0]  s1_sig_r;
  logic        out_valid_r;
  logic [1:0]  out_cls_r;
  logic [1:0]  out_status_r;
  logic        adv;
  logic [1:0]  cls;
  logic [1:0]  status_nxt;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  gosq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gosq_classify #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (adv),
    .fix_present (s1_fix_r),
    .obs_time_ms (s1_time_r),
    .accuracy_cm (s1_acc_r),
    .dop_x100    (s1_dop_r),
    .signal_x10  (s1_sig_r),
    .cfg         (cfg),
    .cls         (cls)
  );

  gosq_status #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_status (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (adv),
    .cls         (cls),
    .persistence (cfg.persistence),
    .status_nxt  (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_fix_r  <= in_fix_present;
      s1_time_r <= in_obs_time_ms;
      s1_acc_r  <= in_accuracy_cm;
      s1_dop_r  <= in_dop_x100;
      s1_sig_r  <= in_signal_x10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cls_r    <= cls;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_instant_class = out_cls_r;
  assign out_nav_status    = out_status_r;

endmodule
`default_nettype wire

FILE: src/gosq_checker.sv
// Port-level checker of the GNSS outage status qualifier and its bind.
`default_nettype none
module gosq_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_instant_class,
  input wire logic [1:0] out_nav_status
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nav_status)
      && $stable(out_instant_class))
    else $error("result changed while stalled");

  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_instant_class != gosq_pkg::CLS_RECOVERING)
    else $error("instant class out of range");

  // Leaving outage toward good always passes through recovering.
  a_no_direct_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_nav_status == gosq_pkg::CLS_OUTAGE
      |=> !(out_valid && out_nav_status == gosq_pkg::CLS_GOOD))
    else $error("status went from outage straight to good");

  // A result appears no earlier than the edge after its transaction is accepted.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result appeared without an earlier transaction");

endmodule

bind gnss_outage_status_qualifier_top gosq_checker u_gosq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_instant_class (out_instant_class),
  .out_nav_status    (out_nav_status)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the GNSS outage status qualifier: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        fix;
    logic [31:0] time_ms;
    logic [15:0] acc_cm;
    logic [15:0] dop;
    logic [9:0]  sig;
  } fix_obs_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [1:0] nav;
  } nav_report_t;

  typedef enum logic {STEP_OBS, STEP_CFG} step_kind_t;
  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_style_t;
  typedef enum int {
    CFG_STYLE_RESET, CFG_STYLE_TYPICAL, CFG_STYLE_ZERO, CFG_STYLE_FULL, CFG_STYLE_WILD
  } cfg_style_t;

  typedef struct packed {
    step_kind_t                      kind;
    logic [gosq_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [gosq_pkg::CFG_DATA_W-1:0] reg_data;
    fix_obs_t                        obs;
    logic                            known;
    nav_report_t                     want;
  } script_row_t;

  localparam logic [gosq_pkg::CFG_IDX_W-1:0] REG_UNUSED = '1;
  localparam int HOLD_CYCLES = 200;

  localparam script_row_t SCRIPT [31] = '{
    '{STEP_OBS, '0, '0, '{1'b1, 32'd0, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_GOOD}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd100, 16'hFFFF, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_GOOD}},
    '{STEP_OBS, '0, '0, '{1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 10'h3FF}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_GOOD}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd200, 16'd0, 16'hFFFF, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_OUTAGE}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd300, 16'd1, 16'd1, 10'h3FF}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_OUTAGE}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd400, 16'd1, 16'd1, 10'h3FF}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_OUTAGE}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd500, 16'd1, 16'd1, 10'h3FF}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_RECOVERING}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd600, 16'd1, 16'd1, 10'h3FF}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_RECOVERING}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd700, 16'd1, 16'd1, 10'h3FF}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_RECOVERING}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd800, 16'd1, 16'd1, 10'h3FF}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_GOOD}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd2801, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_GOOD}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd4801, 16'd1500, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_DEGRADED, gosq_pkg::CLS_GOOD}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'd4800, 16'd0, 16'd200, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_DEGRADED, gosq_pkg::CLS_GOOD}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h8000_12C0, 16'd0, 16'd0, 10'd300}, 1'b1,
      '{gosq_pkg::CLS_DEGRADED, gosq_pkg::CLS_DEGRADED}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h8000_12C0, 16'd0, 16'd0, 10'd200}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_DEGRADED}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'hFFFF_FFFF, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_DEGRADED}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0000_03E8, 16'd1499, 16'd199, 10'd301}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_DEGRADED}},
    '{STEP_CFG, gosq_pkg::REG_PERSISTENCE, 20'd0, '0, 1'b0, '0},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0000_03F2, 16'd5000, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_OUTAGE}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0000_03FC, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_RECOVERING}},
    '{STEP_CFG, gosq_pkg::REG_OUTAGE_ACC_CM, 20'd0, '0, 1'b0, '0},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0000_0406, 16'd1, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_OUTAGE}},
    '{STEP_CFG, gosq_pkg::REG_MAX_GAP_MS, 20'd0, '0, 1'b0, '0},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0000_0407, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_OUTAGE}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0000_0407, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_GOOD, gosq_pkg::CLS_RECOVERING}},
    '{STEP_CFG, REG_UNUSED, 20'hFFFFF, '0, 1'b0, '0},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0000_0408, 16'd0, 16'd0, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_OUTAGE}},
    '{STEP_CFG, gosq_pkg::REG_MAX_GAP_MS, 20'hFFFFF, '0, 1'b0, '0},
    '{STEP_CFG, gosq_pkg::REG_PERSISTENCE, 20'hFFFFF, '0, 1'b0, '0},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0010_0407, 16'd0, 16'hFFFF, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_OUTAGE, gosq_pkg::CLS_OUTAGE}},
    '{STEP_OBS, '0, '0, '{1'b1, 32'h0010_0408, 16'd0, 16'd300, 10'd0}, 1'b1,
      '{gosq_pkg::CLS_DEGRADED, gosq_pkg::CLS_OUTAGE}}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [gosq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gosq_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_fix_present;
  logic [31:0]                     in_obs_time_ms;
  logic [15:0]                     in_accuracy_cm;
  logic [15:0]                     in_dop_x100;
  logic [9:0]                      in_signal_x10;
  logic                            out_valid;
  logic                            out_ready;
  logic [1:0]                      out_instant_class;
  logic [1:0]                      out_nav_status;

  gosq_pkg::cfg_t cfg_shadow;
  logic [1:0]     nav_state;
  logic [1:0]     candidate_cls;
  logic [7:0]     streak;
  logic [31:0]    last_fix_ms;
  logic           fix_seen;
  nav_report_t    expected_reports[$];

  int        mismatches = 0;
  rx_style_t rx_mode = RX_ALWAYS;
  int        hold_requests = 0;
  int        hold_served = 0;
  bit        sender_gaps = 1'b1;
  int        burst_left = 0;
  logic [31:0] gen_ms = '0;

  gnss_outage_status_qualifier_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_fix_present    (in_fix_present),
    .in_obs_time_ms    (in_obs_time_ms),
    .in_accuracy_cm    (in_accuracy_cm),
    .in_dop_x100       (in_dop_x100),
    .in_signal_x10     (in_signal_x10),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_instant_class (out_instant_class),
    .out_nav_status    (out_nav_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [1:0] grade_obs(fix_obs_t o);
    logic [31:0] gap;
    gap = o.time_ms - last_fix_ms;
    if (!o.fix) return gosq_pkg::CLS_OUTAGE;
    if (fix_seen && !gap[31] && gap > {12'd0, cfg_shadow.max_gap_ms})
      return gosq_pkg::CLS_OUTAGE;
    if (o.acc_cm != '0) begin
      if (o.acc_cm >= cfg_shadow.outage_acc_cm) return gosq_pkg::CLS_OUTAGE;
      if (o.acc_cm >= cfg_shadow.degraded_acc_cm) return gosq_pkg::CLS_DEGRADED;
    end
    if (o.dop != '0) begin
      if (o.dop >= cfg_shadow.outage_dop) return gosq_pkg::CLS_OUTAGE;
      if (o.dop >= cfg_shadow.degraded_dop) return gosq_pkg::CLS_DEGRADED;
    end
    if (o.sig != '0) begin
      if (o.sig <= cfg_shadow.outage_signal) return gosq_pkg::CLS_OUTAGE;
      if (o.sig <= cfg_shadow.degraded_signal) return gosq_pkg::CLS_DEGRADED;
    end
    return gosq_pkg::CLS_GOOD;
  endfunction

  task automatic qualify_obs(input fix_obs_t o, output nav_report_t r);
    logic [1:0] cls;
    cls = grade_obs(o);
    if (o.fix) begin
      last_fix_ms = o.time_ms;
      fix_seen = 1'b1;
    end
    if (cls == nav_state) begin
      streak = '0;
      candidate_cls = nav_state;
    end else begin
      if (cls == candidate_cls) begin
        if (streak != 8'hFF) streak = streak + 8'd1;
      end else begin
        candidate_cls = cls;
        streak = 8'd1;
      end
      if (streak >= cfg_shadow.persistence) begin
        nav_state = (nav_state == gosq_pkg::CLS_OUTAGE && candidate_cls == gosq_pkg::CLS_GOOD) ?
                    gosq_pkg::CLS_RECOVERING : candidate_cls;
        streak = '0;
        candidate_cls = nav_state;
      end
    end
    r.cls = cls;
    r.nav = nav_state;
  endtask

  task automatic write_reg(input logic [gosq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gosq_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gosq_pkg::REG_MAX_GAP_MS:      cfg_shadow.max_gap_ms = data;
      gosq_pkg::REG_OUTAGE_ACC_CM:   cfg_shadow.outage_acc_cm = data[15:0];
      gosq_pkg::REG_DEGRADED_ACC_CM: cfg_shadow.degraded_acc_cm = data[15:0];
      gosq_pkg::REG_OUTAGE_DOP:      cfg_shadow.outage_dop = data[15:0];
      gosq_pkg::REG_DEGRADED_DOP:    cfg_shadow.degraded_dop = data[15:0];
      gosq_pkg::REG_OUTAGE_SIGNAL:   cfg_shadow.outage_signal = data[9:0];
      gosq_pkg::REG_DEGRADED_SIGNAL: cfg_shadow.degraded_signal = data[9:0];
      gosq_pkg::REG_PERSISTENCE:     cfg_shadow.persistence = data[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input gosq_pkg::cfg_t c);
    write_reg(gosq_pkg::REG_MAX_GAP_MS, c.max_gap_ms);
    write_reg(gosq_pkg::REG_OUTAGE_ACC_CM, {4'd0, c.outage_acc_cm});
    write_reg(gosq_pkg::REG_DEGRADED_ACC_CM, {4'd0, c.degraded_acc_cm});
    write_reg(gosq_pkg::REG_OUTAGE_DOP, {4'd0, c.outage_dop});
    write_reg(gosq_pkg::REG_DEGRADED_DOP, {4'd0, c.degraded_dop});
    write_reg(gosq_pkg::REG_OUTAGE_SIGNAL, {10'd0, c.outage_signal});
    write_reg(gosq_pkg::REG_DEGRADED_SIGNAL, {10'd0, c.degraded_signal});
    write_reg(gosq_pkg::REG_PERSISTENCE, {12'd0, c.persistence});
    write_reg(REG_UNUSED, gosq_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_obs(input fix_obs_t o, input logic known, input nav_report_t want);
    nav_report_t r;
    if (sender_gaps && burst_left == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_fix_present <= o.fix;
    in_obs_time_ms <= o.time_ms;
    in_accuracy_cm <= o.acc_cm;
    in_dop_x100 <= o.dop;
    in_signal_x10 <= o.sig;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    qualify_obs(o, r);
    expected_reports.push_back(known ? want : r);
    if (burst_left > 0) burst_left--;
  endtask

  function automatic logic [15:0] pick_level(logic [15:0] hi_thr, logic [15:0] lo_thr,
                                             logic [15:0] span);
    logic [15:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) v = '0;
    else if (r < 35) v = hi_thr + 16'($urandom_range(0, 2)) - 16'd1;
    else if (r < 50) v = lo_thr + 16'($urandom_range(0, 2)) - 16'd1;
    else v = 16'($urandom);
    return v & span;
  endfunction

  function automatic gosq_pkg::cfg_t build_cfg(cfg_style_t style);
    gosq_pkg::cfg_t c;
    logic [127:0] noise;
    c = gosq_pkg::CFG_RESET;
    case (style)
      CFG_STYLE_ZERO: c = '0;
      CFG_STYLE_FULL: c = '1;
      CFG_STYLE_TYPICAL: begin
        c.max_gap_ms = 20'($urandom_range(50, 5000));
        c.degraded_acc_cm = 16'($urandom_range(1, 30000));
        c.outage_acc_cm = c.degraded_acc_cm + 16'($urandom_range(0, 30000));
        c.degraded_dop = 16'($urandom_range(1, 2000));
        c.outage_dop = c.degraded_dop + 16'($urandom_range(0, 3000));
        c.outage_signal = 10'($urandom_range(0, 500));
        c.degraded_signal = c.outage_signal + 10'($urandom_range(0, 500));
        c.persistence = 8'($urandom_range(1, 4));
      end
      CFG_STYLE_WILD: begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        c = noise[$bits(gosq_pkg::cfg_t)-1:0];
      end
      default: ;
    endcase
    return c;
  endfunction

  // A long run holds one good template so the persistence counter can climb to its top.
  task automatic run_phase(input int count, input bit long_run);
    fix_obs_t tpl;
    fix_obs_t o;
    int sent;
    int reps;
    int r;
    logic [31:0] step;
    sent = 0;
    while (sent < count) begin
      tpl.fix = ($urandom_range(0, 99) < 85);
      tpl.time_ms = '0;
      tpl.acc_cm = pick_level(cfg_shadow.outage_acc_cm, cfg_shadow.degraded_acc_cm, 16'hFFFF);
      tpl.dop = pick_level(cfg_shadow.outage_dop, cfg_shadow.degraded_dop, 16'hFFFF);
      tpl.sig = 10'(pick_level({6'd0, cfg_shadow.outage_signal},
                               {6'd0, cfg_shadow.degraded_signal}, 16'h03FF));
      reps = $urandom_range(1, 6);
      if (long_run) begin
        tpl = '0;
        tpl.fix = 1'b1;
        reps = 260;
        long_run = 1'b0;
      end
      for (int k = 0; k < reps; k++) begin
        o = tpl;
        r = $urandom_range(0, 99);
        if (reps > 6) step = 32'($urandom_range(0, 1000));
        else if (r < 70) step = 32'($urandom_range(0, cfg_shadow.max_gap_ms));
        else if (r < 80) step = {12'd0, cfg_shadow.max_gap_ms} + 32'($urandom_range(0, 2));
        else if (r < 88) step = -32'($urandom_range(1, 1000));
        else if (r < 93) step = 32'h8000_0000 + 32'($urandom_range(0, 2)) - 32'd1;
        else step = $urandom;
        gen_ms = gen_ms + step;
        o.time_ms = gen_ms;
        if (reps <= 6 && $urandom_range(0, 19) == 0) o.fix = ~o.fix;
        send_obs(o, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    int cyc;
    int hold_left;
    cyc = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_left == 0 && hold_served < hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_MOSTLY:  out_ready <= ($urandom_range(0, 99) < 75);
          RX_SPARSE:  out_ready <= ($urandom_range(0, 99) < 30);
          RX_PATTERN: out_ready <= ((cyc % 7) < 4);
          default:    out_ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    nav_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transaction: class %0d status %0d",
                   out_instant_class, out_nav_status);
      end else begin
        want = expected_reports.pop_front();
        if (out_instant_class !== want.cls || out_nav_status !== want.nav) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected class %0d status %0d, got class %0d status %0d",
                     want.cls, want.nav, out_instant_class, out_nav_status);
        end
      end
    end
  end

  initial begin
    gosq_pkg::cfg_t c;
    int n;
    bit long_run;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_fix_present = 1'b0;
    in_obs_time_ms = '0;
    in_accuracy_cm = '0;
    in_dop_x100 = '0;
    in_signal_x10 = '0;
    cfg_shadow = gosq_pkg::CFG_RESET;
    nav_state = gosq_pkg::CLS_GOOD;
    candidate_cls = gosq_pkg::CLS_GOOD;
    streak = '0;
    last_fix_ms = '0;
    fix_seen = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rx_mode = RX_MOSTLY;
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == STEP_CFG) begin
        drain();
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_data);
      end else begin
        send_obs(SCRIPT[i].obs, SCRIPT[i].known, SCRIPT[i].want);
      end
    end
    gen_ms = 32'h0010_0408;

    for (int p = 0; p < 8; p++) begin
      drain();
      n = 70;
      long_run = 1'b0;
      case (p)
        0: begin
          c = build_cfg(CFG_STYLE_RESET);
          rx_mode = RX_MOSTLY;
          sender_gaps = 1'b1;
        end
        1: begin
          c = build_cfg(CFG_STYLE_TYPICAL);
          rx_mode = RX_PATTERN;
          sender_gaps = 1'b1;
        end
        2: begin
          c = build_cfg(CFG_STYLE_ZERO);
          rx_mode = RX_ALWAYS;
          sender_gaps = 1'b0;
        end
        3: begin
          c = build_cfg(CFG_STYLE_FULL);
          rx_mode = RX_ALWAYS;
          sender_gaps = 1'b0;
          n = 300;
          long_run = 1'b1;
        end
        4: begin
          c = build_cfg(CFG_STYLE_WILD);
          c.persistence = 8'($urandom_range(0, 3));
          rx_mode = RX_SPARSE;
          sender_gaps = 1'b1;
        end
        5: begin
          c = build_cfg(CFG_STYLE_TYPICAL);
          c.persistence = 8'd2;
          rx_mode = RX_ALWAYS;
          sender_gaps = 1'b0;
        end
        6: begin
          c = build_cfg(CFG_STYLE_TYPICAL);
          c.persistence = 8'($urandom_range(1, 6));
          rx_mode = RX_MOSTLY;
          sender_gaps = 1'b1;
        end
        default: begin
          c = build_cfg(CFG_STYLE_RESET);
          c.persistence = 8'd1;
          rx_mode = RX_PATTERN;
          sender_gaps = 1'b0;
        end
      endcase
      program_regs(c);
      // The receiver stalls for a long stretch while the sender keeps offering transactions.
      if (p == 5) hold_requests++;
      run_phase(n, long_run);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
